// ===== hw/rtl/fgsa_pkg.sv =====
package fgsa_pkg;

  // Row count limit: a group holds at most 2^COUNT_BITS rows.
  localparam int COUNT_BITS = 26;
  localparam int CNT_W      = COUNT_BITS + 1;

  // Group store geometry.
  localparam int GROUPS = 6;
  localparam int GRP_W  = $clog2(GROUPS);
  localparam logic [GRP_W-1:0] LAST_GRP = GRP_W'(GROUPS - 1);

  // Return flag code that belongs to no group.
  localparam logic [1:0] FLAG_NONE = 2'd3;

  // Cutoff after reset: 19981111, that is 1998-11-11.
  localparam logic [26:0] CUTOFF_RESET = 27'd19981111;

  // Product widths: price * (100 - disc) and that times (100 + tax).
  localparam int FACT_W = 7;
  localparam int DP_W   = 31;
  localparam int CH_W   = 38;
  localparam logic [FACT_W-1:0] HUNDRED = FACT_W'(100);

  // Accumulator widths.
  localparam int QTY_SUM_W   = 32;
  localparam int PRICE_SUM_W = 50;
  localparam int DP_SUM_W    = 57;
  localparam int DP_OUT_W    = 56;
  localparam int CH_SUM_W    = 63;
  localparam int DISC_SUM_W  = 30;

  // Queue between the front and the back.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef struct packed {
    logic [1:0]  return_flag;
    logic        line_status;
    logic [5:0]  quantity;
    logic [26:0] ship_date;
    logic [23:0] price_cents;
    logic [3:0]  discount_pct;
    logic [3:0]  tax_pct;
    logic        end_of_run;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  group_flag;
    logic        group_status;
    logic [31:0] qty_total;
    logic [49:0] price_total;
    logic [55:0] disc_price_total;
    logic [62:0] charge_total;
    logic [29:0] discount_total;
    logic [26:0] rows_counted;
    logic        overflowed;
    logic        last_group;
  } out_word_t;

  // First front stage: classified row with the discounted price.
  typedef struct packed {
    logic             acc;
    logic [GRP_W-1:0] grp;
    logic [5:0]       qty;
    logic [23:0]      price;
    logic [3:0]       disc;
    logic [3:0]       tax;
    logic             eor;
    logic [DP_W-1:0]  dp;
  } stage_t;

  // Queue entry handed to the back.
  typedef struct packed {
    logic             acc;
    logic [GRP_W-1:0] grp;
    logic [5:0]       qty;
    logic [23:0]      price;
    logic [3:0]       disc;
    logic             eor;
    logic [DP_W-1:0]  dp;
    logic [CH_W-1:0]  ch;
  } row_t;

  // One group's running sums.
  typedef struct packed {
    logic [QTY_SUM_W-1:0]   qty;
    logic [PRICE_SUM_W-1:0] price;
    logic [DP_SUM_W-1:0]    dp;
    logic [CH_SUM_W-1:0]    ch;
    logic [DISC_SUM_W-1:0]  disc;
    logic [CNT_W-1:0]       cnt;
    logic                   sat;
  } grp_acc_t;

  typedef enum logic {
    BK_RUN,
    BK_FLUSH
  } back_state_t;

endpackage

// ===== hw/rtl/fgsa_front.sv =====
module fgsa_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [26:0]          cfg_wr_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  fgsa_pkg::in_word_t   in_data,
  output logic                 row_valid,
  input  logic                 row_ready,
  output fgsa_pkg::row_t       row_data
);

  logic [26:0]      cutoff;
  logic             s1_valid;
  fgsa_pkg::stage_t s1;
  logic             s1_ready;
  logic             s2_ready;
  logic             pass;
  logic             keep;
  logic [fgsa_pkg::FACT_W-1:0] disc_factor;
  logic [fgsa_pkg::FACT_W-1:0] tax_factor;
  logic [fgsa_pkg::DP_W-1:0]   dp_calc;
  logic [fgsa_pkg::CH_W-1:0]   ch_calc;

  // Cutoff register; the user must write it only while the block is idle, unchecked here.
  always_ff @(posedge clk) begin
    if (rst) begin
      cutoff <= fgsa_pkg::CUTOFF_RESET;
    end else if (cfg_wr_en) begin
      cutoff <= cfg_wr_data;
    end
  end

  // Filter: a row counts when its flag names a group and it shipped in time.
  // Rows that neither count nor end the run are dropped here.
  assign pass = (in_data.return_flag != fgsa_pkg::FLAG_NONE) &&
                (in_data.ship_date <= cutoff);
  assign keep = pass || in_data.end_of_run;

  // First multiply: price times (100 - discount).
  assign disc_factor = fgsa_pkg::HUNDRED - fgsa_pkg::FACT_W'(in_data.discount_pct);
  assign dp_calc = fgsa_pkg::DP_W'(in_data.price_cents) * fgsa_pkg::DP_W'(disc_factor);

  // Second multiply: discounted price times (100 + tax).
  assign tax_factor = fgsa_pkg::HUNDRED + fgsa_pkg::FACT_W'(s1.tax);
  assign ch_calc = fgsa_pkg::CH_W'(s1.dp) * fgsa_pkg::CH_W'(tax_factor);

  // Two-stage pipeline; each stage moves when the one after it has room.
  assign s2_ready = !row_valid || row_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign in_ready = s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      row_valid <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid <= in_valid && keep;
      end
      if (s2_ready) begin
        row_valid <= s1_valid;
      end
    end
  end

  // Payload registers of both stages.
  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      s1.acc   <= pass;
      s1.grp   <= fgsa_pkg::GRP_W'({in_data.return_flag, in_data.line_status});
      s1.qty   <= in_data.quantity;
      s1.price <= in_data.price_cents;
      s1.disc  <= in_data.discount_pct;
      s1.tax   <= in_data.tax_pct;
      s1.eor   <= in_data.end_of_run;
      s1.dp    <= dp_calc;
    end
    if (s2_ready && s1_valid) begin
      row_data.acc   <= s1.acc;
      row_data.grp   <= s1.grp;
      row_data.qty   <= s1.qty;
      row_data.price <= s1.price;
      row_data.disc  <= s1.disc;
      row_data.eor   <= s1.eor;
      row_data.dp    <= s1.dp;
      row_data.ch    <= ch_calc;
    end
  end

endmodule

// ===== hw/rtl/fgsa_fifo.sv =====
module fgsa_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  fgsa_pkg::row_t wr_data,
  output logic           rd_valid,
  input  logic           rd_ready,
  output fgsa_pkg::row_t rd_data
);

  fgsa_pkg::row_t mem [fgsa_pkg::FIFO_DEPTH];
  logic [fgsa_pkg::FIFO_AW-1:0] wr_ptr;
  logic [fgsa_pkg::FIFO_AW-1:0] rd_ptr;
  logic [fgsa_pkg::FIFO_AW:0]   count;
  logic push;
  logic pop;

  assign wr_ready = (count != (fgsa_pkg::FIFO_AW + 1)'(fgsa_pkg::FIFO_DEPTH));
  assign rd_valid = (count != '0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_data  = mem[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == fgsa_pkg::FIFO_AW'(fgsa_pkg::FIFO_DEPTH - 1)) ?
                  '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == fgsa_pkg::FIFO_AW'(fgsa_pkg::FIFO_DEPTH - 1)) ?
                  '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/fgsa_back.sv =====
module fgsa_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                row_valid,
  output logic                row_ready,
  input  fgsa_pkg::row_t      row_data,
  output logic                out_valid,
  input  logic                out_ready,
  output fgsa_pkg::out_word_t out_data
);

  fgsa_pkg::back_state_t state;
  fgsa_pkg::back_state_t state_next;
  fgsa_pkg::grp_acc_t    acc [fgsa_pkg::GROUPS];
  fgsa_pkg::grp_acc_t    cur;
  fgsa_pkg::grp_acc_t    upd;
  logic [fgsa_pkg::GRP_W-1:0] idx;
  logic pop;
  logic load;
  logic last;

  assign row_ready = (state == fgsa_pkg::BK_RUN);
  assign pop       = row_valid && row_ready;
  assign load      = (state == fgsa_pkg::BK_FLUSH) && (!out_valid || out_ready);
  assign last      = (idx == fgsa_pkg::LAST_GRP);

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fgsa_pkg::BK_RUN;
    end else begin
      state <= state_next;
    end
  end

  // Run until an end-of-run word is taken, then flush all six groups.
  always_comb begin
    state_next = state;
    case (state)
      fgsa_pkg::BK_RUN: begin
        if (pop && row_data.eor) begin
          state_next = fgsa_pkg::BK_FLUSH;
        end
      end
      fgsa_pkg::BK_FLUSH: begin
        if (load && last) begin
          state_next = fgsa_pkg::BK_RUN;
        end
      end
      default: begin
        state_next = fgsa_pkg::BK_RUN;
      end
    endcase
  end

  // Add one row to its group, or mark the group saturated when its count is full.
  always_comb begin
    cur = acc[row_data.grp];
    upd = cur;
    if (cur.cnt[fgsa_pkg::COUNT_BITS]) begin
      upd.sat = 1'b1;
    end else begin
      upd.qty   = cur.qty + fgsa_pkg::QTY_SUM_W'(row_data.qty);
      upd.price = cur.price + fgsa_pkg::PRICE_SUM_W'(row_data.price);
      upd.dp    = cur.dp + fgsa_pkg::DP_SUM_W'(row_data.dp);
      upd.ch    = cur.ch + fgsa_pkg::CH_SUM_W'(row_data.ch);
      upd.disc  = cur.disc + fgsa_pkg::DISC_SUM_W'(row_data.disc);
      upd.cnt   = cur.cnt + 1'b1;
    end
  end

  // Group store. During a flush the groups shift down one place per result,
  // so the head is always the group being reported and zeros fill from the top.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < fgsa_pkg::GROUPS; i++) begin
        acc[i] <= '0;
      end
    end else if (load) begin
      for (int i = 0; i < fgsa_pkg::GROUPS - 1; i++) begin
        acc[i] <= acc[i+1];
      end
      acc[fgsa_pkg::GROUPS-1] <= '0;
    end else if (pop && row_data.acc) begin
      acc[row_data.grp] <= upd;
    end
  end

  // Flush position.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (load) begin
      idx <= last ? '0 : idx + 1'b1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data.group_flag       <= idx[fgsa_pkg::GRP_W-1:1];
      out_data.group_status     <= idx[0];
      out_data.qty_total        <= acc[0].qty;
      out_data.price_total      <= acc[0].price;
      out_data.disc_price_total <= acc[0].dp[fgsa_pkg::DP_OUT_W-1:0];
      out_data.charge_total     <= acc[0].ch;
      out_data.discount_total   <= acc[0].disc;
      out_data.rows_counted     <= 27'(acc[0].cnt);
      out_data.overflowed       <= acc[0].sat;
      out_data.last_group       <= last;
    end
  end

  // No row is taken from the queue while a flush is under way.
  assert property (@(posedge clk) disable iff (rst)
    (state == fgsa_pkg::BK_FLUSH) |-> !pop)
    else $error("row taken during flush");

  // The last group of a flush is flag two, status one.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.last_group) |->
      (out_data.group_flag == 2'd2 && out_data.group_status == 1'b1))
    else $error("last group carries wrong label");

  // Loading the sixth group ends the flush.
  assert property (@(posedge clk) disable iff (rst)
    (load && last) |=> (state == fgsa_pkg::BK_RUN && idx == '0))
    else $error("flush did not end after sixth group");

  // A saturated group has a full count.
  assert property (@(posedge clk) disable iff (rst)
    acc[0].sat |-> acc[0].cnt[fgsa_pkg::COUNT_BITS])
    else $error("head group saturated below its limit");

endmodule

// ===== hw/rtl/filtered_group_sum_aggregator.sv =====
// Q1-style pricing summary over a stream of order line words.
//
// Input channel (in_valid / in_ready / in_data) takes one row per cycle while
// in_ready is high. A row whose ship date is at or before the cutoff is added into
// one of six groups chosen by return flag and line status; return flag three
// counts nowhere. An end_of_run row is counted if it qualifies, then the block
// sends six result words on the output channel (out_valid / out_ready / out_data),
// groups in order (0,0), (0,1), (1,0), (1,1), (2,0), (2,1), the last one flagged,
// and clears every group.
// The cutoff is written through cfg_wr_en / cfg_wr_data; the user must do so only
// while the block is idle, which the block does not enforce. Throughput is one
// row per cycle outside a flush, set by the accumulate in the back. A flush sends
// one result word per cycle while out_ready is high. The end-of-run row passes
// the second multiply stage, the queue and the accumulate; the first result word
// then leaves the output register. While the receiver stalls, the flush holds;
// the four-entry queue and the front stages fill, after which in_ready drops.
// Reset clears all groups, empties the pipeline and sets the cutoff to 19981111.
module filtered_group_sum_aggregator (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [26:0]         cfg_wr_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  fgsa_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output fgsa_pkg::out_word_t out_data
);

  logic           f_valid;
  logic           f_ready;
  fgsa_pkg::row_t f_data;
  logic           q_valid;
  logic           q_ready;
  fgsa_pkg::row_t q_data;

  // Front: filter, classify and form the products.
  fgsa_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .row_valid   (f_valid),
    .row_ready   (f_ready),
    .row_data    (f_data)
  );

  // Queue that lets front and back stall independently.
  fgsa_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  (f_data),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_data)
  );

  // Back: group sums and the flush sequencer.
  fgsa_back u_back (
    .clk       (clk),
    .rst       (rst),
    .row_valid (q_valid),
    .row_ready (q_ready),
    .row_data  (q_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
